// ----- sv/lsps_pkg.sv -----
// Shared types, widths, register indexes and constants for the line sensor PID steering block.
package lsps_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int TIME_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int ACC_W      = 24;
  localparam int DRIVE_W    = 24;
  localparam int ERR_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int DIV_STEPS  = 19;
  localparam int DIV_CNT_W  = 5;

  localparam logic [15:0] MIN_INTERVAL = 16'd0;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_THR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INT_MIN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INT_MAX   = 3'd7;

  localparam logic [SAMPLE_W-1:0]     THR_RESET     = 10'd250;
  localparam logic signed [ACC_W-1:0] INT_MIN_RESET = -24'sd25600;
  localparam logic signed [ACC_W-1:0] INT_MAX_RESET = 24'sd25600;

  localparam logic signed [ERR_W-1:0] ERR_CENTER     = 3'sd0;
  localparam logic signed [ERR_W-1:0] ERR_LEFT_NEAR  = 3'sd1;
  localparam logic signed [ERR_W-1:0] ERR_RIGHT_NEAR = -3'sd1;
  localparam logic signed [ERR_W-1:0] ERR_RIGHT_FAR  = -3'sd2;
  localparam logic signed [ERR_W-1:0] ERR_LEFT_FAR   = 3'sd2;
  localparam logic signed [ERR_W-1:0] ERR_LOST_NEG   = -3'sd3;
  localparam logic signed [ERR_W-1:0] ERR_LOST_POS   = 3'sd3;

  localparam logic signed [DRIVE_W+1:0] DRIVE_MAX = 26'sd8388607;
  localparam logic signed [DRIVE_W+1:0] DRIVE_MIN = -26'sd8388608;

  typedef struct packed {
    logic [SAMPLE_W-1:0]     left_thr;
    logic [SAMPLE_W-1:0]     mid_thr;
    logic [SAMPLE_W-1:0]     right_thr;
    logic signed [GAIN_W-1:0] kp;
    logic signed [GAIN_W-1:0] ki;
    logic signed [GAIN_W-1:0] kd;
    logic signed [ACC_W-1:0]  int_min;
    logic signed [ACC_W-1:0]  int_max;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic integ;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic held;
    logic dt_zero;
  } status_t;

endpackage

// ----- sv/lsps_ifs.sv -----
// Handshake channel interfaces for sensor requests, steering results and register writes.
interface lsps_in_if;
  logic                          valid;
  logic                          ready;
  logic [lsps_pkg::SAMPLE_W-1:0] left_sample;
  logic [lsps_pkg::SAMPLE_W-1:0] mid_sample;
  logic [lsps_pkg::SAMPLE_W-1:0] right_sample;
  logic [lsps_pkg::TIME_W-1:0]   now_ms;

  modport source(output valid, left_sample, mid_sample, right_sample, now_ms, input ready);
  modport sink(input valid, left_sample, mid_sample, right_sample, now_ms, output ready);
endinterface

interface lsps_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lsps_pkg::DRIVE_W-1:0] drive;
  logic signed [lsps_pkg::ERR_W-1:0]   error_code;
  logic                                updated;

  modport source(output valid, drive, error_code, updated, input ready);
  modport sink(input valid, drive, error_code, updated, output ready);
endinterface

interface lsps_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lsps_pkg::CFG_IDX_W-1:0]  index;
  logic [lsps_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/lsps_regs.sv -----
// Configuration register file with thresholds, PID gains and integral clamps.
module lsps_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_valid,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [lsps_pkg::CFG_DATA_W-1:0] wr_data,
  output logic                            wr_ready,
  output lsps_pkg::cfg_t                  cfg
);
  import lsps_pkg::*;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_thr  <= THR_RESET;
      cfg.mid_thr   <= THR_RESET;
      cfg.right_thr <= THR_RESET;
      cfg.kp        <= '0;
      cfg.ki        <= '0;
      cfg.kd        <= '0;
      cfg.int_min   <= INT_MIN_RESET;
      cfg.int_max   <= INT_MAX_RESET;
    end else if (wr_valid) begin
      unique case (wr_index)
        REG_LEFT_THR:   cfg.left_thr  <= wr_data[SAMPLE_W-1:0];
        REG_MID_THR:    cfg.mid_thr   <= wr_data[SAMPLE_W-1:0];
        REG_RIGHT_THR:  cfg.right_thr <= wr_data[SAMPLE_W-1:0];
        REG_PROP_GAIN:  cfg.kp        <= $signed(wr_data[GAIN_W-1:0]);
        REG_INTEG_GAIN: cfg.ki        <= $signed(wr_data[GAIN_W-1:0]);
        REG_DERIV_GAIN: cfg.kd        <= $signed(wr_data[GAIN_W-1:0]);
        REG_INT_MIN:    cfg.int_min   <= $signed(wr_data[ACC_W-1:0]);
        REG_INT_MAX:    cfg.int_max   <= $signed(wr_data[ACC_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/lsps_ctrl.sv -----
// Controller state machine that sequences capture, multiplies, integral, division and result.
module lsps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lsps_pkg::status_t status,
  output lsps_pkg::cmd_t    cmd
);
  import lsps_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL1   = 3'd1;
  localparam logic [2:0] ST_MUL2   = 3'd2;
  localparam logic [2:0] ST_INTEG  = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] cnt_next;
  logic                 out_valid_next;
  logic                 out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = status.held ? ST_FINISH : ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.integ  = 1'b1;
        cnt_next   = '0;
        state_next = status.dt_zero ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- sv/lsps_dp.sv -----
// Datapath with error classification, PID multiplies, integral clamp, serial divider and state.
module lsps_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  lsps_pkg::cfg_t                      cfg,
  input  lsps_pkg::cmd_t                      cmd,
  output lsps_pkg::status_t                   status,
  input  logic [lsps_pkg::SAMPLE_W-1:0]       left_sample,
  input  logic [lsps_pkg::SAMPLE_W-1:0]       mid_sample,
  input  logic [lsps_pkg::SAMPLE_W-1:0]       right_sample,
  input  logic [lsps_pkg::TIME_W-1:0]         now_ms,
  output logic signed [lsps_pkg::DRIVE_W-1:0] drive,
  output logic signed [lsps_pkg::ERR_W-1:0]   error_code,
  output logic                                updated
);
  import lsps_pkg::*;

  logic signed [ERR_W-1:0]   prev_error;
  logic signed [ERR_W-1:0]   older_error;
  logic signed [ACC_W-1:0]   integral_acc;
  logic [TIME_W-1:0]         last_update_ms;
  logic signed [DRIVE_W-1:0] last_drive;

  logic signed [ERR_W-1:0]   err;
  logic [TIME_W-1:0]         dt;
  logic [TIME_W-1:0]         now_q;
  logic                      held;
  logic                      dt_zero;

  logic signed [18:0]        p_term;
  logic signed [18:0]        ki_err;
  logic                      num_neg;
  logic [DIV_STEPS-1:0]      num_mag;
  logic signed [51:0]        integ_prod;
  logic signed [ACC_W-1:0]   acc_new;
  logic [TIME_W-1:0]         rem;
  logic [DIV_STEPS-1:0]      quot;

  logic                      lo_on;
  logic                      mo_on;
  logic                      ro_on;
  logic signed [ERR_W-1:0]   err_next;
  logic [TIME_W-1:0]         dt_next;
  logic signed [3:0]         err_diff;
  logic signed [19:0]        kd_x;
  logic signed [19:0]        diff_x;
  logic signed [19:0]        pd_full;
  logic [19:0]               pd_abs;
  logic signed [51:0]        dt_x;
  logic signed [52:0]        integ_sum;
  logic signed [52:0]        integ_hi;
  logic [TIME_W:0]           rem_sh;
  logic                      q_bit;
  logic signed [19:0]        d_term;
  logic signed [DRIVE_W+1:0] drive_sum;
  logic signed [DRIVE_W-1:0] drive_sat;

  assign status.held    = held;
  assign status.dt_zero = dt_zero;

  assign lo_on   = left_sample  >= cfg.left_thr;
  assign mo_on   = mid_sample   >= cfg.mid_thr;
  assign ro_on   = right_sample >= cfg.right_thr;
  assign dt_next = now_ms - last_update_ms;

  always_comb begin
    err_next = prev_error;
    unique case ({lo_on, mo_on, ro_on})
      3'b010: err_next = ERR_CENTER;
      3'b110: err_next = ERR_LEFT_NEAR;
      3'b011: err_next = ERR_RIGHT_NEAR;
      3'b001: err_next = ERR_RIGHT_FAR;
      3'b100: err_next = ERR_LEFT_FAR;
      3'b000: begin
        if (prev_error < 0 && older_error < 0) begin
          err_next = ERR_LOST_NEG;
        end else if (prev_error > 0 && older_error > 0) begin
          err_next = ERR_LOST_POS;
        end
      end
      default: err_next = prev_error;
    endcase
  end

  assign err_diff = 4'(err) - 4'(prev_error);
  assign kd_x     = 20'(cfg.kd);
  assign diff_x   = 20'(err_diff);
  assign pd_full  = kd_x * diff_x;
  assign pd_abs   = pd_full[19] ? 20'(-pd_full) : 20'(pd_full);

  assign dt_x       = $signed(52'(dt));
  assign integ_sum  = 53'(integral_acc) + 53'(integ_prod);
  assign integ_hi   = (integ_sum > 53'(cfg.int_max)) ? 53'(cfg.int_max) : integ_sum;

  assign rem_sh = {rem, num_mag[DIV_STEPS-1]};
  assign q_bit  = rem_sh >= {1'b0, dt};

  always_comb begin
    if (dt_zero) begin
      d_term = '0;
    end else if (num_neg) begin
      d_term = -$signed({1'b0, quot});
    end else begin
      d_term = $signed({1'b0, quot});
    end
    drive_sum = 26'(p_term) + 26'(acc_new) + 26'(d_term);
    if (drive_sum > DRIVE_MAX) begin
      drive_sat = DRIVE_MAX[DRIVE_W-1:0];
    end else if (drive_sum < DRIVE_MIN) begin
      drive_sat = DRIVE_MIN[DRIVE_W-1:0];
    end else begin
      drive_sat = drive_sum[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err     <= err_next;
      dt      <= dt_next;
      now_q   <= now_ms;
      held    <= dt_next < TIME_W'(MIN_INTERVAL);
      dt_zero <= dt_next == '0;
    end
    if (cmd.mul1) begin
      p_term  <= 19'(cfg.kp) * 19'(err);
      ki_err  <= 19'(cfg.ki) * 19'(err);
      num_neg <= pd_full[19];
      num_mag <= pd_abs[DIV_STEPS-1:0];
    end
    if (cmd.mul2) begin
      integ_prod <= 52'(ki_err) * dt_x;
      rem        <= '0;
      quot       <= '0;
    end
    if (cmd.integ) begin
      if (integ_hi < 53'(cfg.int_min)) begin
        acc_new <= cfg.int_min;
      end else begin
        acc_new <= integ_hi[ACC_W-1:0];
      end
    end
    if (cmd.div_step) begin
      rem     <= q_bit ? rem_sh[TIME_W-1:0] - dt : rem_sh[TIME_W-1:0];
      quot    <= {quot[DIV_STEPS-2:0], q_bit};
      num_mag <= {num_mag[DIV_STEPS-2:0], 1'b0};
    end
    if (cmd.finish) begin
      if (held) begin
        drive      <= last_drive;
        error_code <= prev_error;
        updated    <= 1'b0;
      end else begin
        drive      <= drive_sat;
        error_code <= err;
        updated    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error     <= '0;
      older_error    <= '0;
      integral_acc   <= '0;
      last_update_ms <= '0;
      last_drive     <= '0;
    end else if (cmd.finish && !held) begin
      prev_error     <= err;
      older_error    <= prev_error;
      integral_acc   <= acc_new;
      last_update_ms <= now_q;
      last_drive     <= drive_sat;
    end
  end

endmodule

// ----- sv/line_sensor_pid_steering.sv -----
// A request is captured, then passes the two multiply steps, the integral step and the 19-step
// serial divider for the D term; with zero elapsed time the divider is skipped. Held requests (inside
// the minimum interval) go from the first multiply step straight to the result. A new request is taken only when idle.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) clears the error history, integral, time and drive,
// and loads the register defaults.
module line_sensor_pid_steering (
  input logic       clk,
  input logic       rst,
  lsps_in_if.sink   sensor,
  lsps_out_if.source steer,
  lsps_cfg_if.sink  cfg
);
  import lsps_pkg::*;

  cfg_t    regs;
  cmd_t    cmd;
  status_t status;

  lsps_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .wr_ready (cfg.ready),
    .cfg      (regs)
  );

  lsps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sensor.valid),
    .in_ready  (sensor.ready),
    .out_valid (steer.valid),
    .out_ready (steer.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lsps_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (regs),
    .cmd          (cmd),
    .status       (status),
    .left_sample  (sensor.left_sample),
    .mid_sample   (sensor.mid_sample),
    .right_sample (sensor.right_sample),
    .now_ms       (sensor.now_ms),
    .drive        (steer.drive),
    .error_code   (steer.error_code),
    .updated      (steer.updated)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sensor.valid && sensor.ready |=> !sensor.ready)
    else $error("Request accepted while the previous one is still in work.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!steer.valid || steer.ready))
    else $error("Result register loaded while it still holds an untaken result.");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    steer.valid && steer.ready && !cmd.finish |=> !steer.valid)
    else $error("Result repeated after it was taken.");

  a_error_range: assert property (@(posedge clk) disable iff (rst)
    steer.valid |-> steer.error_code != 3'b100)
    else $error("Error code outside the range -3 to 3.");

endmodule
